### rtl/grc_pkg.sv
// grid ray caster package: payload structs, fixed-point constants, register indexes
// no dependencies
package grc_pkg;

	localparam int MAP_W_DEF = 64;
	localparam int MAP_H_DEF = 64;
	localparam int SCREEN_COLS_DEF = 640;

	localparam logic [23:0] DIST_MAX = 24'hFFFFFF;

	localparam logic [2:0] REG_PLAYER_X = 3'd0;
	localparam logic [2:0] REG_PLAYER_Y = 3'd1;
	localparam logic [2:0] REG_DIR_X    = 3'd2;
	localparam logic [2:0] REG_DIR_Y    = 3'd3;
	localparam logic [2:0] REG_PLANE_X  = 3'd4;
	localparam logic [2:0] REG_PLANE_Y  = 3'd5;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_CAST  = 1'b1;

	typedef struct packed {
		logic       func;
		logic [9:0] column;
		logic [5:0] cell_x;
		logic [5:0] cell_y;
		logic       cell_is_wall;
	} in_word_t;

	typedef struct packed {
		logic [5:0]  hit_cell_x;
		logic [5:0]  hit_cell_y;
		logic        hit_side;
		logic [23:0] perp_distance;
	} out_word_t;

	// request/response of the shared divider
	typedef struct packed {
		logic        start;
		logic [33:0] dividend;
		logic [33:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [33:0] quotient;
	} div_rsp_t;

endpackage

### rtl/grid_ray_caster_top.sv
// Grid ray caster. A write word stores one wall flag. A cast word first runs a setup: a
// 34-bit shift-subtract divider, shared for the camera value and both reciprocals, and a
// shared multiplier step for each product. It then walks the map cell by cell, each cell
// taking a step, a registered read of the map memory and a test, and finally loads the
// result. A pending result holds off the next word until it is taken. After reset a
// clearing pass over all MAP_W*MAP_H cells runs before the first word is taken;
// configuration writes are accepted throughout. Cells outside the map are walls.
// depends on grc_pkg, grc_div, grc_map
module grid_ray_caster_top #(
	parameter int MAP_W = grc_pkg::MAP_W_DEF,
	parameter int MAP_H = grc_pkg::MAP_H_DEF,
	parameter int SCREEN_COLS = grc_pkg::SCREEN_COLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  grc_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output grc_pkg::out_word_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [21:0]        cfg_data
);

	localparam int AW = $clog2(MAP_W * MAP_H);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CAM   = 4'd1;
	localparam logic [3:0] ST_MULX  = 4'd2;
	localparam logic [3:0] ST_MULY  = 4'd3;
	localparam logic [3:0] ST_DIVX  = 4'd4;
	localparam logic [3:0] ST_DIVY  = 4'd5;
	localparam logic [3:0] ST_SIDX  = 4'd6;
	localparam logic [3:0] ST_SIDY  = 4'd7;
	localparam logic [3:0] ST_STEP  = 4'd8;
	localparam logic [3:0] ST_RD    = 4'd9;
	localparam logic [3:0] ST_TEST  = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;

	logic [21:0] px_q, py_q;
	logic signed [17:0] dx_q, dy_q, plx_q, ply_q;

	logic [3:0]  st_q;
	logic signed [27:0] cam_q;
	logic signed [34:0] rx_q, ry_q;
	logic [32:0] ddx_q, ddy_q;
	logic [40:0] sx_q, sy_q;
	logic [40:0] dist_q;
	logic signed [9:0] mx_q, my_q;
	logic        side_q;
	logic        nx_q, ny_q;
	logic [9:0]  col_q;
	grc_pkg::out_word_t res_q;
	logic        res_v_q;

	// shared multiplier: 34x28 signed, result registered
	logic signed [33:0] mul_a;
	logic signed [27:0] mul_b;
	logic signed [61:0] mul_p_q;
	logic [1:0]  mcnt_q;

	grc_pkg::div_req_t div_req;
	grc_pkg::div_rsp_t div_rsp;
	logic        div_go_q;

	logic        clear_busy;
	logic        map_rd;
	logic [AW-1:0] rd_addr;
	logic        wr_en;
	logic [AW-1:0] wr_addr;

	grc_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	grc_map #(.MAP_W(MAP_W), .MAP_H(MAP_H)) u_map (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_addr(wr_addr),
		.wr_data(in_data.cell_is_wall), .rd_addr(rd_addr), .rd_data(map_rd),
		.clear_busy(clear_busy)
	);

	assign cfg_ready = 1'b1;
	assign in_stall = (st_q != ST_IDLE) || clear_busy || res_v_q;
	assign out_valid = res_v_q;
	assign out_data = res_q;

	logic accept;
	assign accept = in_valid && !in_stall;

	assign wr_en = accept && (in_data.func == grc_pkg::FUNC_WRITE) &&
		({3'b0, in_data.cell_x} < 9'(MAP_W)) && ({3'b0, in_data.cell_y} < 9'(MAP_H));
	assign wr_addr = AW'(in_data.cell_y) * AW'(MAP_W) + AW'(in_data.cell_x);
	assign rd_addr = AW'(my_q[7:0]) * AW'(MAP_W) + AW'(mx_q[7:0]);

	// magnitudes and boundary fractions
	logic [34:0] rx_mag, ry_mag;
	assign rx_mag = rx_q[34] ? 35'(-rx_q) : 35'(rx_q);
	assign ry_mag = ry_q[34] ? 35'(-ry_q) : 35'(ry_q);
	logic [16:0] fx, fy;
	assign fx = nx_q ? {1'b0, px_q[15:0]} : 17'h10000 - {1'b0, px_q[15:0]};
	assign fy = ny_q ? {1'b0, py_q[15:0]} : 17'h10000 - {1'b0, py_q[15:0]};

	// floor(v/65536) for signed product
	logic signed [45:0] prod_fl;
	assign prod_fl = 46'(mul_p_q >>> 16);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (st_q)
			ST_MULX: begin mul_a = 34'(plx_q); mul_b = cam_q; end
			ST_MULY: begin mul_a = 34'(ply_q); mul_b = cam_q; end
			ST_SIDX: begin mul_a = {1'b0, ddx_q}; mul_b = 28'({1'b0, fx}); end
			ST_SIDY: begin mul_a = {1'b0, ddy_q}; mul_b = 28'({1'b0, fy}); end
			default: ;
		endcase
	end

	always_comb begin
		div_req.start = div_go_q;
		div_req.dividend = '0;
		div_req.divisor = 34'd1;
		unique case (st_q)
			ST_CAM: begin
				div_req.dividend = 34'({col_q, 17'd0});
				div_req.divisor = 34'(SCREEN_COLS);
			end
			ST_DIVX: begin
				div_req.dividend = 34'h1_0000_0000;
				div_req.divisor = (rx_mag == 0) ? 34'd1 : rx_mag[33:0];
			end
			ST_DIVY: begin
				div_req.dividend = 34'h1_0000_0000;
				div_req.divisor = (ry_mag == 0) ? 34'd1 : ry_mag[33:0];
			end
			default: ;
		endcase
	end

	logic out_x, out_y;
	assign out_x = mx_q[9] || (mx_q >= 10'(MAP_W));
	assign out_y = my_q[9] || (my_q >= 10'(MAP_H));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q  <= 22'd131072;
			py_q  <= 22'd131072;
			dx_q  <= -18'sd65536;
			dy_q  <= '0;
			plx_q <= '0;
			ply_q <= 18'sd43254;
			st_q  <= ST_IDLE;
			res_v_q <= 1'b0;
			div_go_q <= 1'b0;
			mcnt_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					grc_pkg::REG_PLAYER_X: px_q <= cfg_data;
					grc_pkg::REG_PLAYER_Y: py_q <= cfg_data;
					grc_pkg::REG_DIR_X:    dx_q <= cfg_data[17:0];
					grc_pkg::REG_DIR_Y:    dy_q <= cfg_data[17:0];
					grc_pkg::REG_PLANE_X:  plx_q <= cfg_data[17:0];
					grc_pkg::REG_PLANE_Y:  ply_q <= cfg_data[17:0];
					default: ;
				endcase
			end
			if (res_v_q && !out_stall) res_v_q <= 1'b0;
			div_go_q <= 1'b0;
			mcnt_q <= mcnt_q + 2'd1;
			unique case (st_q)
				ST_IDLE: begin
					if (accept && in_data.func == grc_pkg::FUNC_CAST) begin
						st_q <= ST_CAM;
						div_go_q <= 1'b1;
					end
				end
				ST_CAM: if (div_rsp.done) begin
					st_q <= ST_MULX;
					mcnt_q <= '0;
				end
				ST_MULX: if (mcnt_q == 2'd3) begin
					st_q <= ST_MULY;
					mcnt_q <= '0;
				end
				ST_MULY: if (mcnt_q == 2'd3) begin
					st_q <= ST_DIVX;
					div_go_q <= 1'b1;
				end
				ST_DIVX: if (div_rsp.done) begin
					st_q <= ST_DIVY;
					div_go_q <= 1'b1;
				end
				ST_DIVY: if (div_rsp.done) begin
					st_q <= ST_SIDX;
					mcnt_q <= '0;
				end
				ST_SIDX: if (mcnt_q == 2'd3) begin
					st_q <= ST_SIDY;
					mcnt_q <= '0;
				end
				ST_SIDY: if (mcnt_q == 2'd3) st_q <= ST_STEP;
				ST_STEP: st_q <= ST_RD;
				ST_RD:   st_q <= ST_TEST;
				// cells off the map count as walls
				ST_TEST: st_q <= (map_rd || out_x || out_y) ? ST_OUT : ST_STEP;
				ST_OUT: begin
					if (!res_v_q) begin
						res_v_q <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
		if (st_q == ST_IDLE && accept) begin
			col_q <= in_data.column;
		end
		unique case (st_q)
			ST_CAM: if (div_rsp.done)
				cam_q <= $signed(div_rsp.quotient[27:0]) - 28'sd65536;
			ST_MULX: if (mcnt_q == 2'd3) begin
				rx_q <= 35'(dx_q) + 35'(prod_fl);
				nx_q <= 1'b0;
			end
			ST_MULY: if (mcnt_q == 2'd3) begin
				ry_q <= 35'(dy_q) + 35'(prod_fl);
				nx_q <= rx_q[34];
			end
			ST_DIVX: begin
				ny_q <= ry_q[34];
				if (div_rsp.done) ddx_q <= (rx_mag == 0) ? 33'h1_0000_0000 : div_rsp.quotient[32:0];
			end
			ST_DIVY: if (div_rsp.done)
				ddy_q <= (ry_mag == 0) ? 33'h1_0000_0000 : div_rsp.quotient[32:0];
			ST_SIDX: if (mcnt_q == 2'd3) sx_q <= 41'(mul_p_q[61:16]);
			ST_SIDY: if (mcnt_q == 2'd3) begin
				sy_q <= 41'(mul_p_q[61:16]);
				mx_q <= 10'(px_q[21:16]);
				my_q <= 10'(py_q[21:16]);
			end
			ST_STEP: begin
				if (sx_q < sy_q) begin
					mx_q <= nx_q ? mx_q - 10'sd1 : mx_q + 10'sd1;
					dist_q <= sx_q;
					sx_q <= sx_q + 41'(ddx_q);
					side_q <= 1'b0;
				end else begin
					my_q <= ny_q ? my_q - 10'sd1 : my_q + 10'sd1;
					dist_q <= sy_q;
					sy_q <= sy_q + 41'(ddy_q);
					side_q <= 1'b1;
				end
			end
			ST_OUT: begin
				res_q.hit_cell_x <= mx_q[5:0];
				res_q.hit_cell_y <= my_q[5:0];
				res_q.hit_side <= side_q;
				res_q.perp_distance <= (dist_q > 41'(grc_pkg::DIST_MAX)) ?
					grc_pkg::DIST_MAX : dist_q[23:0];
			end
			default: ;
		endcase
	end

endmodule

### rtl/grc_div.sv
// grc_div: shared restoring divider, one quotient bit per cycle
// depends on grc_pkg
module grc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  grc_pkg::div_req_t req,
	output grc_pkg::div_rsp_t rsp
);

	logic [33:0] rem_q;
	logic [33:0] quo_q;
	logic [33:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [34:0] trial;
	logic [34:0] shifted;

	assign shifted = {rem_q, quo_q[33]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd34;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[34]) begin
				rem_q <= trial[33:0];
				quo_q <= {quo_q[32:0], 1'b1};
			end else begin
				rem_q <= shifted[33:0];
				quo_q <= {quo_q[32:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

### rtl/grc_map.sv
// grc_map: wall map memory with a clearing pass after reset
// depends on grc_pkg
module grc_map #(
	parameter int MAP_W = grc_pkg::MAP_W_DEF,
	parameter int MAP_H = grc_pkg::MAP_H_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [$clog2(MAP_W*MAP_H)-1:0]         wr_addr,
	input  logic                                   wr_data,
	input  logic [$clog2(MAP_W*MAP_H)-1:0]         rd_addr,
	output logic                                   rd_data,
	output logic                                   clear_busy
);

	localparam int DEPTH = MAP_W * MAP_H;
	localparam int AW = $clog2(DEPTH);

	logic          mem [DEPTH];
	logic [AW:0]   clr_q;

	assign clear_busy = (clr_q != (AW+1)'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clear_busy) begin
			clr_q <= clr_q + (AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (clear_busy) begin
			mem[clr_q[AW-1:0]] <= 1'b0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### rtl/grc_checker.sv
// grc_checker: port-level checks of the grid ray caster, bound to the top level
// depends on grc_pkg
module grc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input grc_pkg::in_word_t  in_data,
	input logic               out_valid,
	input logic               out_stall,
	input grc_pkg::out_word_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result word dropped or changed while stalled");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.func == grc_pkg::FUNC_CAST |=> in_stall)
		else $error("new word taken right after a cast");

	a_no_result_and_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");

endmodule

bind grid_ray_caster_top grc_checker u_grc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
